// ===== rtl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg - shared types and constants for the cursor sequence unit
// Operation and status codes, default sizes and the types passed between the
// sequencer, the element memory and the top level.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int unsigned DepthDef     = 256;
  localparam int unsigned ElemWidthDef = 32;
  localparam int unsigned OpWidth      = 3;
  localparam int unsigned ValWidth     = 32;

  typedef enum logic [OpWidth-1:0] {
    OP_CLEAR      = 3'd0,
    OP_INS_BEFORE = 3'd1,
    OP_INS_AT     = 3'd2,
    OP_DELETE     = 3'd3,
    OP_READ       = 3'd4,
    OP_ADVANCE    = 3'd5,
    OP_REWIND     = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ELEM = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // Memory port strobes
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctrl_t;

  // One finished result
  typedef struct packed {
    logic signed [ValWidth-1:0] point_value;
    status_e                    status;
    logic                       at_end;
    logic                       seq_empty;
  } res_t;

endpackage

// ===== rtl/cst_mem.sv =====
// ----------------------------------------------------------------------------
// cst_mem - gap buffer element memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cst_mem #(
  parameter int unsigned DEPTH      = cst_pkg::DepthDef,
  parameter int unsigned ELEM_WIDTH = cst_pkg::ElemWidthDef,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  cst_pkg::mem_ctrl_t     ctrl_i,
  input  logic [AW-1:0]          waddr_i,
  input  logic [ELEM_WIDTH-1:0]  wdata_i,
  input  logic [AW-1:0]          raddr_i,
  output logic [ELEM_WIDTH-1:0]  rdata_o
);
  import cst_pkg::*;

  logic [ELEM_WIDTH-1:0] mem_q [DEPTH];
  logic [ELEM_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctrl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cst_seq.sv =====
// ----------------------------------------------------------------------------
// cst_seq - operation sequencer for the two-stack gap buffer
// Holds both stack counts, drives the single memory port pair and walks the
// left stack element by element on rewind.
// ----------------------------------------------------------------------------
module cst_seq #(
  parameter int unsigned DEPTH      = cst_pkg::DepthDef,
  parameter int unsigned ELEM_WIDTH = cst_pkg::ElemWidthDef,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [cst_pkg::OpWidth-1:0]    operation_i,
  input  logic signed [cst_pkg::ValWidth-1:0] value_i,
  output cst_pkg::mem_ctrl_t             mem_ctrl_o,
  output logic [AW-1:0]                  mem_waddr_o,
  output logic [ELEM_WIDTH-1:0]          mem_wdata_o,
  output logic [AW-1:0]                  mem_raddr_o,
  input  logic [ELEM_WIDTH-1:0]          mem_rdata_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output cst_pkg::res_t                  res_o
);
  import cst_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [CW-1:0] OneC   = CW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADV,
    S_REW,
    S_RD,
    S_OUT
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] before_q, before_d;
  logic [CW-1:0] after_q, after_d;
  status_e       status_q, status_d;

  logic [CW:0]           fill;
  logic                  full;
  logic [AW-1:0]         ptr_addr;
  logic [AW-1:0]         below_addr;
  logic [AW-1:0]         left_addr;
  logic [AW-1:0]         left_top_addr;
  logic [AW-1:0]         left_next_addr;
  logic signed [63:0]    value_ext;
  logic [ELEM_WIDTH-1:0] elem_in;
  logic signed [ELEM_WIDTH-1:0] rd_elem;
  logic signed [63:0]    rd_ext;

  assign fill           = {1'b0, before_q} + {1'b0, after_q};
  assign full           = (fill >= {1'b0, DepthC});
  assign ptr_addr       = AW'(DepthC - after_q);
  assign below_addr     = AW'(DepthC - after_q - OneC);
  assign left_addr      = AW'(before_q);
  assign left_top_addr  = AW'(before_q - OneC);
  assign left_next_addr = AW'(before_q - CW'(2));

  assign value_ext = 64'(value_i);
  assign elem_in   = value_ext[ELEM_WIDTH-1:0];
  assign rd_elem   = mem_rdata_i;
  assign rd_ext    = 64'(rd_elem);

  always_comb begin
    state_d     = state_q;
    before_d    = before_q;
    after_d     = after_q;
    status_d    = status_q;
    mem_ctrl_o  = '0;
    mem_waddr_o = left_addr;
    mem_wdata_o = elem_in;
    mem_raddr_o = ptr_addr;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          status_d = ST_OK;
          state_d  = S_RD;
          case (op_e'(operation_i))
            OP_CLEAR: begin
              before_d = '0;
              after_d  = '0;
            end
            OP_INS_BEFORE: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                mem_ctrl_o.we = 1'b1;
                mem_waddr_o   = left_addr;
                before_d      = before_q + OneC;
              end
            end
            OP_INS_AT: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                mem_ctrl_o.we = 1'b1;
                mem_waddr_o   = below_addr;
                after_d       = after_q + OneC;
              end
            end
            OP_DELETE: begin
              if (after_q == '0) begin
                status_d = ST_NO_ELEM;
              end else begin
                after_d = after_q - OneC;
              end
            end
            OP_READ: begin
              if (after_q == '0) begin
                status_d = ST_NO_ELEM;
              end
            end
            OP_ADVANCE: begin
              if (after_q == '0) begin
                status_d = ST_NO_ELEM;
              end else begin
                mem_ctrl_o.re = 1'b1;
                mem_raddr_o   = ptr_addr;
                state_d       = S_ADV;
              end
            end
            OP_REWIND: begin
              if (before_q != '0) begin
                mem_ctrl_o.re = 1'b1;
                mem_raddr_o   = left_top_addr;
                state_d       = S_REW;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ADV: begin
        // move the element at the point onto the left stack
        mem_ctrl_o.we = 1'b1;
        mem_waddr_o   = left_addr;
        mem_wdata_o   = mem_rdata_i;
        before_d      = before_q + OneC;
        after_d       = after_q - OneC;
        state_d       = S_RD;
      end
      S_REW: begin
        // write the pending left top below the right stack, prefetch the next
        mem_ctrl_o.we = 1'b1;
        mem_waddr_o   = below_addr;
        mem_wdata_o   = mem_rdata_i;
        after_d       = after_q + OneC;
        before_d      = before_q - OneC;
        if (before_q > OneC) begin
          mem_ctrl_o.re = 1'b1;
          mem_raddr_o   = left_next_addr;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (after_q != '0) begin
          mem_ctrl_o.re = 1'b1;
          mem_raddr_o   = ptr_addr;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      before_q <= '0;
      after_q  <= '0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      before_q <= before_d;
      after_q  <= after_d;
      status_q <= status_d;
    end
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign res_o.point_value = (after_q != '0) ? rd_ext[ValWidth-1:0] : '0;
  assign res_o.status      = status_q;
  assign res_o.at_end      = (after_q == '0);
  assign res_o.seq_empty   = (after_q == '0) && (before_q == '0);

endmodule

// ===== rtl/cursor_sequence_two_stack_unit.sv =====
// ----------------------------------------------------------------------------
// cursor_sequence_two_stack_unit - integer sequence with a cursor
// Gap buffer in one memory: left stack grows up from entry 0, right stack
// (point and after) grows down from the last entry.
//
//   channel  direction  signals
//   input    in         in_valid_i, in_ready_o, operation_i, value_i
//   output   out        out_valid_o, out_ready_i, point_value_o, status_o,
//                       at_end_o, seq_empty_o
//
// Clear, insert, delete and read go from the input transfer through the read
// state (S_RD) and the output state (S_OUT) into the output register; advance
// adds an extra memory read then write of the point element (S_ADV). On rewind
// the left stack moves one element per cycle (S_REW) through the single read
// and write port pair.
// Reset clears both counts; the memory itself is not cleared.
// A new item is taken once the previous result sits in the output register.
// ----------------------------------------------------------------------------
module cursor_sequence_two_stack_unit #(
  parameter int unsigned DEPTH      = cst_pkg::DepthDef,
  parameter int unsigned ELEM_WIDTH = cst_pkg::ElemWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [cst_pkg::OpWidth-1:0]         operation_i,
  input  logic signed [cst_pkg::ValWidth-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cst_pkg::ValWidth-1:0] point_value_o,
  output logic [1:0]                          status_o,
  output logic                                at_end_o,
  output logic                                seq_empty_o
);
  import cst_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  mem_ctrl_t             mem_ctrl;
  logic [AW-1:0]         mem_waddr;
  logic [ELEM_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [ELEM_WIDTH-1:0] mem_rdata;
  logic                  res_valid;
  logic                  res_ready;
  res_t                  res;

  logic out_valid_q, out_valid_d;
  res_t res_q;

  cst_seq #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .mem_ctrl_o  (mem_ctrl),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  cst_mem #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .ctrl_i  (mem_ctrl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register: load when empty or draining this cycle
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_value_o = res_q.point_value;
  assign status_o      = res_q.status;
  assign at_end_o      = res_q.at_end;
  assign seq_empty_o   = res_q.seq_empty;

`ifndef SYNTHESIS
  // busy right after a transfer in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an item is in progress");

  // nothing at the point reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && at_end_o) |-> (point_value_o == '0))
    else $error("nonzero point value at end of sequence");

  // an empty sequence is always at its end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && seq_empty_o) |-> at_end_o)
    else $error("empty sequence not flagged at end");

  // a full store cannot be reported when the sequence is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL)) |-> !seq_empty_o)
    else $error("store full reported on empty sequence");
`endif

endmodule
